// ----- hdl/assert_macros.svh -----
// Assertion macros used by the top-level RTL file of the generator polynomial block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property must hold at every clock edge outside reset.
`define ASSERT_AT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define ASSERT_AT(label, clk, rstn, prop, msg)
`define ASSERT_NEVER(label, clk, rstn, cond, msg)

`endif

`endif

// ----- hdl/rsgp_pkg.sv -----
// Package with GF(2^8) arithmetic for the generator polynomial block.
package rsgp_pkg;

    localparam int unsigned GF_BITS = 8;

    typedef logic [GF_BITS-1:0] gf_t;

    // Shift-and-add multiply; red is the low byte of the reduction polynomial.
    function automatic gf_t gf_mul(input gf_t a, input gf_t b, input gf_t red);
        logic [GF_BITS:0] x;
        gf_t              acc;
        begin
            x   = {1'b0, a};
            acc = '0;
            for (int i = 0; i < GF_BITS; i++)
            begin
                if (b[i])
                begin
                    acc = acc ^ x[GF_BITS-1:0];
                end
                x = {x[GF_BITS-1:0], 1'b0};
                if (x[GF_BITS])
                begin
                    x = {1'b0, x[GF_BITS-1:0] ^ red};
                end
            end
            return acc;
        end
    endfunction

    // Multiply by the field generator 2.
    function automatic gf_t gf_xtime(input gf_t a, input gf_t red);
        begin
            return a[GF_BITS-1] ? ({a[GF_BITS-2:0], 1'b0} ^ red) : {a[GF_BITS-2:0], 1'b0};
        end
    endfunction

endpackage

// ----- hdl/rs_generator_polynomial_unit.sv -----
// Reed-Solomon generator polynomial builder over GF(2^8), top level.
// For degree n the coefficients are built in place in one RAM, one coefficient per cycle
// through its one write port and one read port.
// Output then streams n+1 coefficients at one per cycle while m_tready is high.
// A degree-zero request is accepted but produces no output.
// One request is processed at a time. Reset returns to idle with field polynomial 0x11D.
`include "assert_macros.svh"

module rs_generator_polynomial_unit
    import rsgp_pkg::*;
#(
    parameter int MAX_DEGREE = 63
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [5:0] degree, [7:6] zero
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] coefficient
    output logic       m_tlast,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [8:0] cfg_data   // [8:0] field_polynomial
);

    localparam int AW    = $clog2(MAX_DEGREE + 1);
    localparam int DEG_W = 6;
    localparam int CW    = (AW > DEG_W) ? AW : DEG_W;
    localparam logic [CW-1:0] MAX_N = CW'(MAX_DEGREE);
    localparam gf_t POLY_RESET = 8'h1D;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_SETUP,
        ST_STEP,
        ST_NEXT,
        ST_OUT
    } state_t;

    state_t         state_reg, state_next;
    logic [AW-1:0]  n_reg, n_next;
    logic [AW-1:0]  len_reg, len_next;
    logic [AW-1:0]  k_reg, k_next;
    logic [AW-1:0]  j_reg, j_next;
    gf_t            held_reg, held_next;
    gf_t            root_reg, root_next;
    gf_t            poly_reg;
    logic           valid_reg, valid_next;
    logic           last_reg, last_next;

    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    gf_t            wr_data;
    logic           rd_en;
    logic [AW-1:0]  rd_addr;
    gf_t            rd_data;

    logic [CW-1:0]  deg_ext;
    logic [CW-1:0]  deg_sat;

    assign deg_ext = CW'(s_tdata[DEG_W-1:0]);
    assign deg_sat = (deg_ext > MAX_N) ? MAX_N : deg_ext;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = valid_reg;
    assign m_tdata   = rd_data;
    assign m_tlast   = last_reg;

    rsgp_ram #(
        .WIDTH (GF_BITS),
        .DEPTH (MAX_DEGREE + 1)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        len_next   = len_reg;
        k_next     = k_reg;
        j_next     = j_reg;
        held_next  = held_reg;
        root_next  = root_reg;
        valid_next = valid_reg;
        last_next  = last_reg;
        wr_en      = 1'b0;
        wr_addr    = k_reg;
        wr_data    = held_reg ^ gf_mul(rd_data, root_reg, poly_reg);
        rd_en      = 1'b0;
        rd_addr    = k_reg - AW'(1);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    n_next = deg_sat[AW-1:0];
                    if (deg_sat != '0)
                    begin
                        state_next = ST_INIT;
                    end
                end
            end
            ST_INIT:
            begin
                // The leading coefficient is always one.
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_data    = gf_t'(1);
                len_next   = AW'(1);
                root_next  = gf_t'(1);
                state_next = ST_SETUP;
            end
            ST_SETUP:
            begin
                rd_en      = 1'b1;
                rd_addr    = len_reg - AW'(1);
                k_next     = len_reg;
                held_next  = '0;
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                // rd_data is old[k-1]; held_reg is old[k], zero above the top entry.
                wr_en     = 1'b1;
                held_next = rd_data;
                if (k_reg == AW'(1))
                begin
                    state_next = ST_NEXT;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = k_reg - AW'(2);
                    k_next  = k_reg - AW'(1);
                end
            end
            ST_NEXT:
            begin
                if (len_reg == n_reg)
                begin
                    j_next     = '0;
                    state_next = ST_OUT;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = len_reg;
                    k_next     = len_reg + AW'(1);
                    len_next   = len_reg + AW'(1);
                    held_next  = '0;
                    root_next  = gf_xtime(root_reg, poly_reg);
                    state_next = ST_STEP;
                end
            end
            ST_OUT:
            begin
                if (valid_reg && m_tready && last_reg)
                begin
                    valid_next = 1'b0;
                    last_next  = 1'b0;
                    state_next = ST_IDLE;
                end
                else if (!valid_reg || m_tready)
                begin
                    // The RAM read register doubles as the output register.
                    rd_en      = 1'b1;
                    rd_addr    = j_reg;
                    valid_next = 1'b1;
                    last_next  = (j_reg == n_reg);
                    j_next     = j_reg + AW'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            n_reg     <= '0;
            len_reg   <= '0;
            k_reg     <= '0;
            j_reg     <= '0;
            held_reg  <= '0;
            root_reg  <= gf_t'(1);
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
            poly_reg  <= POLY_RESET;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            len_reg   <= len_next;
            k_reg     <= k_next;
            j_reg     <= j_next;
            held_reg  <= held_next;
            root_reg  <= root_next;
            valid_reg <= valid_next;
            last_reg  <= last_next;
            if (cfg_valid)
            begin
                poly_reg <= cfg_data[7:0];
            end
        end
    end

    `ASSERT_NEVER(a_no_rw_collision, clk, rst_n, wr_en && rd_en && (wr_addr == rd_addr), "RAM read and write hit the same entry")
    `ASSERT_NEVER(a_idle_no_output, clk, rst_n, s_tready && m_tvalid, "Output valid while accepting requests")
    `ASSERT_NEVER(a_step_index, clk, rst_n, (state_reg == ST_STEP) && (k_reg == '0), "Update step at index zero")
    `ASSERT_AT(a_last_to_idle, clk, rst_n, (m_tvalid && m_tready && m_tlast) |=> s_tready, "No return to idle after last coefficient")
    `ASSERT_AT(a_len_bound, clk, rst_n, (state_reg == ST_STEP) |-> (len_reg <= n_reg), "Polynomial grew past requested degree")

endmodule

// ----- hdl/rsgp_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module rsgp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        // Read data holds its value while no read is requested.
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- sim/rs_generator_polynomial_unit_test.sv -----
// Self-checking testbench for the Reed-Solomon generator polynomial unit.
module rs_generator_polynomial_unit_test;
    import rsgp_pkg::*;

    localparam int DEGREE_TOP = 63;

    typedef struct packed {
        gf_t  coefficient;
        logic last;
    } coeff_beat_t;

    // Predicts the generator coefficients of each accepted degree and checks the output stream.
    class generator_scoreboard;
        gf_t         red_byte;
        coeff_beat_t expected_coeffs[$];
        int          error_count;

        function new();
            red_byte    = 8'h1D;
            error_count = 0;
        endfunction

        // Only the low byte of the reduction polynomial takes part; bit 8 is implied.
        function void set_field_poly(logic [8:0] poly);
            red_byte = poly[7:0];
        endfunction

        function gf_t times_alpha(gf_t a);
            gf_t s;
            s = {a[6:0], 1'b0};
            if (a[7])
            begin
                s = s ^ red_byte;
            end
            return s;
        endfunction

        // Horner form, most significant bit of b first.
        function gf_t gf_product(gf_t a, gf_t b);
            gf_t acc;
            int  i;
            acc = '0;
            for (i = 7; i >= 0; i--)
            begin
                acc = times_alpha(acc);
                if (b[i])
                begin
                    acc = acc ^ a;
                end
            end
            return acc;
        endfunction

        function void note_degree(logic [5:0] n);
            gf_t coeffs [0:DEGREE_TOP];
            gf_t root;
            int  len;
            int  pass;
            int  k;
            if (n == 0)
            begin
                return;
            end
            coeffs[0] = 8'h01;
            len       = 1;
            root      = 8'h01;
            // Multiply by (x + root) in place; index 0 holds the highest order term.
            for (pass = 0; pass < int'(n); pass++)
            begin
                coeffs[len] = gf_product(coeffs[len-1], root);
                for (k = len - 1; k >= 1; k--)
                begin
                    coeffs[k] = coeffs[k] ^ gf_product(coeffs[k-1], root);
                end
                len++;
                root = times_alpha(root);
            end
            for (k = 0; k < len; k++)
            begin
                expected_coeffs.push_back({coeffs[k], (k == len - 1) ? 1'b1 : 1'b0});
            end
        endfunction

        function void check_coefficient(gf_t c, logic l);
            coeff_beat_t want;
            if (expected_coeffs.size() == 0)
            begin
                $error("coefficient %02h (last %0b) arrived with nothing expected", c, l);
                error_count++;
                return;
            end
            want = expected_coeffs.pop_front();
            if (c !== want.coefficient)
            begin
                $error("coefficient: expected %02h, got %02h", want.coefficient, c);
                error_count++;
            end
            if (l !== want.last)
            begin
                $error("last: expected %0b, got %0b", want.last, l);
                error_count++;
            end
        endfunction
    endclass

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       s_tvalid  = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata   = '0;   // [5:0] degree, [7:6] zero
    logic       m_tvalid;
    logic       m_tready  = 1'b0;
    logic [7:0] m_tdata;          // [7:0] coefficient
    logic       m_tlast;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [8:0] cfg_data  = 9'h11D; // [8:0] field_polynomial

    int send_gap_pct = 25;
    int stall_pct    = 25;

    generator_scoreboard sb = new();

    rs_generator_polynomial_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver side: random stall bursts.
    always
    begin
        @(negedge clk);
        if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct)
        begin
            m_tready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            sb.check_coefficient(m_tdata, m_tlast);
        end
    end

    // Called at a falling edge; returns at a falling edge with valid still high.
    task automatic send_degree(input logic [5:0] degree);
        if (send_gap_pct > 0 && $urandom_range(0, 99) < send_gap_pct)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom_range(0, 255));
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, degree};
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        sb.note_degree(degree);
        @(negedge clk);
    endtask

    // The block must be idle: all coefficients out, and time for a zero-degree request to finish.
    task automatic write_field_poly(input logic [8:0] poly);
        s_tvalid <= 1'b0;
        while (sb.expected_coeffs.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (16) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= poly;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        sb.set_field_poly(poly);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly small degrees; the largest ones are slow.
    function automatic logic [5:0] pick_degree();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            return 6'd0;
        end
        else if (r < 70)
        begin
            return 6'($urandom_range(1, 12));
        end
        else if (r < 94)
        begin
            return 6'($urandom_range(13, 62));
        end
        return 6'd63;
    endfunction

    initial
    begin
        logic [5:0] directed_degrees [14];
        logic [8:0] poly_settings [7];
        int         i;
        int         p;

        directed_degrees = '{6'd1, 6'd2, 6'd3, 6'd0, 6'd63, 6'd0, 6'd0,
                             6'd32, 6'd31, 6'd16, 6'd5, 6'd0, 6'd62, 6'd1};
        // Bit 8 clear in two fixed settings and possibly in the random one; these must behave as if it were set.
        poly_settings = '{9'h100, 9'h1FF, 9'h0FF, 9'h000, 9'h12B,
                          9'($urandom_range(0, 511)), 9'h11D};

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset value of the field polynomial first.
        foreach (directed_degrees[i])
        begin
            send_degree(directed_degrees[i]);
        end
        for (i = 0; i < 36; i++)
        begin
            send_degree(pick_degree());
        end

        for (p = 0; p < 7; p++)
        begin
            send_gap_pct = (p == 2 || p == 6) ? 0 : 25;
            stall_pct    = (p == 2 || p == 6) ? 0 : 25;
            write_field_poly(poly_settings[p]);
            @(negedge clk);
            send_degree(6'd63);
            send_degree(6'd0);
            send_degree(6'd1);
            for (i = 0; i < 28; i++)
            begin
                send_degree(pick_degree());
            end
        end

        s_tvalid <= 1'b0;
        while (sb.expected_coeffs.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (40) @(negedge clk);
        if (sb.error_count == 0 && sb.expected_coeffs.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial
    begin
        #50000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
